FILE: rtl/edfr_pkg.sv
// Package: shared constants and word types for the exit distance field router.
package edfr_pkg;

  localparam int unsigned NodeSlotsDef = 64;
  localparam int unsigned EdgeSlotsDef = 128;
  localparam int unsigned IdBitsDef    = 16;

  localparam logic [7:0] CostInf = 8'hFF;

  localparam logic [2:0] OpAddNode  = 3'd0;
  localparam logic [2:0] OpAddEdge  = 3'd1;
  localparam logic [2:0] OpSetStat  = 3'd2;
  localparam logic [2:0] OpConverge = 3'd3;
  localparam logic [2:0] OpRdStat   = 3'd4;
  localparam logic [2:0] OpRdCost   = 3'd5;
  localparam logic [2:0] OpRdDir    = 3'd6;

  localparam logic [1:0] StNormal = 2'd0;
  localparam logic [1:0] StExit   = 2'd1;
  localparam logic [1:0] StDanger = 2'd2;

  localparam logic [1:0] DirNone = 2'd0;
  localparam logic [1:0] DirA2B  = 2'd1;
  localparam logic [1:0] DirB2A  = 2'd2;
  localparam logic [1:0] DirBlk  = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] item_id;
    logic [15:0] end_a_id;
    logic [15:0] end_b_id;
    logic [1:0]  status_in;
  } in_word_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] status_out;
    logic [7:0] cost_out;
    logic [1:0] direction_out;
  } out_word_t;

endpackage

FILE: rtl/edfr_core.sv
// Sequencer, node and edge memories of the exit distance field router.
module edfr_core import edfr_pkg::*; #(
  parameter int unsigned NodeSlots = NodeSlotsDef,
  parameter int unsigned EdgeSlots = EdgeSlotsDef,
  parameter int unsigned IdBits    = IdBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_word_t  cmd_i,
  output logic      done_o,
  output out_word_t res_o
);

  localparam int unsigned NW = $clog2(NodeSlots);
  localparam int unsigned NF = $clog2(NodeSlots + 1);
  localparam int unsigned EW = (EdgeSlots > 1) ? $clog2(EdgeSlots) : 1;
  localparam int unsigned EF = $clog2(EdgeSlots + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_NSCAN, S_NWAIT, S_NDONE, S_ESCAN, S_EWAIT, S_EDONE,
    S_INIT, S_PASS, S_ERD, S_LA, S_LB, S_RLX, S_RLX2, S_WR,
    S_DRD, S_DLA, S_DLB, S_DGET, S_DCALC, S_OUT
  } state_e;

  // node memory entry: id, status, cost
  logic [IdBits-1:0] nid_mem [NodeSlots];
  logic [1:0]        nst_mem [NodeSlots];
  logic [7:0]        nco_mem [NodeSlots];
  logic [IdBits-1:0] eid_mem [EdgeSlots];
  logic [IdBits-1:0] ea_mem  [EdgeSlots];
  logic [IdBits-1:0] eb_mem  [EdgeSlots];
  logic [1:0]        edr_mem [EdgeSlots];

  state_e            state_q;
  in_word_t          cmd_q;
  out_word_t         res_q;
  logic [NF-1:0]     nfill_q, ni_q, pass_q;
  logic [EF-1:0]     efill_q, ei_q;
  logic              changed_q, done_q;
  logic [NW-1:0]     hit_q, a_q, b_q;
  logic              aok_q;
  logic [IdBits-1:0] key_q, eb_key_q;
  logic [IdBits-1:0] nid_rd, eid_rd, ea_rd, eb_rd;
  logic [1:0]        nst_rd, edr_rd, sa_q, sb_q;
  logic [7:0]        nco_rd, ca_q, cb_q;
  logic [1:0]        st_in;

  assign st_in  = (cmd_q.status_in > StDanger) ? StNormal : cmd_q.status_in;
  assign done_o = done_q;
  assign res_o  = res_q;

  // registered read ports
  logic [NW-1:0] nra;
  logic [EW-1:0] era;
  logic          nwe, ewe, eadd;
  logic [NW-1:0] nwa;
  logic [EW-1:0] ewa;
  logic [1:0]    nwst;
  logic [1:0]    ewdr;
  logic [7:0]    nwco;
  logic [IdBits-1:0] nwid;

  always_ff @(posedge clk_i) begin
    nid_rd <= nid_mem[nra];
    nst_rd <= nst_mem[nra];
    nco_rd <= nco_mem[nra];
    eid_rd <= eid_mem[era];
    ea_rd  <= ea_mem[era];
    eb_rd  <= eb_mem[era];
    edr_rd <= edr_mem[era];
    if (nwe) begin
      nid_mem[nwa] <= nwid;
      nst_mem[nwa] <= nwst;
      nco_mem[nwa] <= nwco;
    end
    if (ewe) begin
      edr_mem[ewa] <= ewdr;
    end
    if (eadd) begin
      eid_mem[ewa] <= cmd_q.item_id[IdBits-1:0];
      ea_mem[ewa]  <= cmd_q.end_a_id[IdBits-1:0];
      eb_mem[ewa]  <= cmd_q.end_b_id[IdBits-1:0];
    end
  end

  // node write: add, set status, init costs, relax; edge write: add, direction
  logic [7:0] relax_co;
  logic       relax_ok;
  always_comb begin
    nwe = 1'b0; nwa = ni_q[NW-1:0]; nwid = nid_rd; nwst = nst_rd; nwco = nco_rd;
    relax_ok = 1'b0; relax_co = 8'd0;
    ewe = 1'b0; eadd = 1'b0; ewa = ei_q[EW-1:0]; ewdr = DirNone;
    case (state_q)
      S_NDONE: begin
        if (cmd_q.opcode == OpAddNode && nfill_q < NF'(NodeSlots)) begin
          nwe = 1'b1; nwa = nfill_q[NW-1:0]; nwid = cmd_q.item_id[IdBits-1:0];
          nwst = st_in; nwco = (st_in == StExit) ? 8'd0 : CostInf;
        end else if (cmd_q.opcode == OpSetStat && aok_q) begin
          nwe = 1'b1; nwa = hit_q; nwid = key_q; nwst = st_in; nwco = ca_q;
        end else if (cmd_q.opcode == OpAddEdge && efill_q < EF'(EdgeSlots)) begin
          eadd = 1'b1; ewe = 1'b1; ewa = efill_q[EW-1:0]; ewdr = DirNone;
        end
      end
      S_INIT: begin
        if (ni_q != '0) begin
          nwe = 1'b1; nwa = NW'(ni_q - 1'b1);
          nwco = (nst_rd == StExit) ? 8'd0 : CostInf;
        end
      end
      S_RLX, S_RLX2: begin
        // target = a in S_RLX (from b), b in S_RLX2 (from a)
        if (state_q == S_RLX) begin
          relax_ok = sa_q != StDanger && sa_q != StExit && sb_q != StDanger &&
                     cb_q != CostInf && ({1'b0, cb_q} + 9'd1 < {1'b0, ca_q});
          relax_co = cb_q + 8'd1; nwa = a_q; nwid = key_q; nwst = sa_q;
        end else begin
          relax_ok = sb_q != StDanger && sb_q != StExit && sa_q != StDanger &&
                     ca_q != CostInf && ({1'b0, ca_q} + 9'd1 < {1'b0, cb_q});
          relax_co = ca_q + 8'd1; nwa = b_q; nwid = eb_key_q; nwst = sb_q;
        end
        nwe = relax_ok; nwco = relax_co;
      end
      S_DCALC: begin
        ewe = 1'b1;
        if (!aok_q) ewdr = DirNone;
        else if (sa_q == StDanger || sb_q == StDanger) ewdr = DirBlk;
        else if (ca_q > cb_q && cb_q != CostInf) ewdr = DirA2B;
        else if (cb_q > ca_q && ca_q != CostInf) ewdr = DirB2A;
        else ewdr = DirNone;
      end
      default: ;
    endcase
  end

  // read address selection
  always_comb begin
    nra = ni_q[NW-1:0];
    era = ei_q[EW-1:0];
    case (state_q)
      S_RLX:  nra = b_q;
      S_RLX2: nra = b_q;
      default: ;
    endcase
  end

  // remember which lookup is running: 0 for A endpoint, 1 for B
  logic lkb_q, dirmode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; nfill_q <= '0; efill_q <= '0; done_q <= 1'b0;
      ni_q <= '0; ei_q <= '0; pass_q <= '0; changed_q <= 1'b0;
      lkb_q <= 1'b0; dirmode_q <= 1'b0; aok_q <= 1'b0;
    end else begin
      done_q <= (state_q == S_OUT);
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            cmd_q <= cmd_i; key_q <= cmd_i.item_id[IdBits-1:0];
            ni_q <= '0; ei_q <= '0; aok_q <= 1'b0;
            res_q <= '0;
            case (cmd_i.opcode)
              OpAddNode, OpAddEdge: state_q <= S_NDONE;
              OpSetStat, OpRdStat, OpRdCost: state_q <= S_NSCAN;
              OpRdDir: state_q <= S_ESCAN;
              OpConverge: state_q <= S_INIT;
              default: state_q <= S_OUT;
            endcase
          end
        end
        // linear node search for key_q; reads are registered
        S_NSCAN: begin
          if (ni_q >= nfill_q) state_q <= S_NDONE;
          else state_q <= S_NWAIT;
        end
        S_NWAIT: begin
          if (nid_rd == key_q) begin
            aok_q <= 1'b1; hit_q <= ni_q[NW-1:0];
            sa_q <= nst_rd; ca_q <= nco_rd;
            state_q <= S_NDONE;
          end else begin
            ni_q <= ni_q + 1'b1; state_q <= S_NSCAN;
          end
        end
        S_NDONE: begin
          state_q <= S_OUT;
          case (cmd_q.opcode)
            OpAddNode: if (nfill_q < NF'(NodeSlots)) begin
              nfill_q <= nfill_q + 1'b1; res_q.accepted <= 1'b1;
            end
            OpAddEdge: if (efill_q < EF'(EdgeSlots)) begin
              efill_q <= efill_q + 1'b1; res_q.accepted <= 1'b1;
            end
            OpSetStat: res_q.accepted <= aok_q;
            OpRdStat: begin
              res_q.accepted <= aok_q; res_q.status_out <= aok_q ? sa_q : StNormal;
            end
            OpRdCost: begin
              res_q.accepted <= aok_q; res_q.cost_out <= aok_q ? ca_q : CostInf;
            end
            default: ;
          endcase
        end
        S_ESCAN: begin
          if (ei_q >= efill_q) state_q <= S_OUT;
          else state_q <= S_EWAIT;
        end
        S_EWAIT: begin
          if (eid_rd == key_q) begin
            res_q.accepted <= 1'b1; res_q.direction_out <= edr_rd;
            state_q <= S_OUT;
          end else begin
            ei_q <= ei_q + 1'b1; state_q <= S_ESCAN;
          end
        end
        // reset costs: read slot ni, write it the next cycle
        S_INIT: begin
          if (ni_q >= nfill_q) begin
            state_q <= S_PASS; pass_q <= '0; changed_q <= 1'b1;
          end else ni_q <= ni_q + 1'b1;
        end
        S_PASS: begin
          ei_q <= '0;
          if (changed_q && pass_q < nfill_q) begin
            pass_q <= pass_q + 1'b1; changed_q <= 1'b0; dirmode_q <= 1'b0;
            state_q <= S_ERD;
          end else begin
            dirmode_q <= 1'b1; state_q <= S_ERD;
          end
        end
        // fetch edge endpoints, then look up A and B by scan
        S_ERD: begin
          if (ei_q >= efill_q) begin
            state_q <= dirmode_q ? S_OUT : S_PASS;
            if (dirmode_q) res_q.accepted <= 1'b1;
          end else state_q <= S_LA;
        end
        S_LA: begin
          key_q <= ea_rd; eb_key_q <= eb_rd; ni_q <= '0;
          lkb_q <= 1'b0; aok_q <= 1'b0; state_q <= S_LB;
        end
        S_LB: begin
          // scan: S_LB issues read of ni_q, S_DRD checks it
          if (ni_q >= nfill_q) begin
            if (dirmode_q) begin
              aok_q <= 1'b0; state_q <= S_DCALC;
            end else begin
              ei_q <= ei_q + 1'b1; state_q <= S_ERD;
            end
          end else state_q <= S_DRD;
        end
        S_DRD: begin
          if (nid_rd == (lkb_q ? eb_key_q : key_q)) begin
            if (!lkb_q) begin
              a_q <= ni_q[NW-1:0]; lkb_q <= 1'b1; ni_q <= '0; state_q <= S_LB;
            end else begin
              b_q <= ni_q[NW-1:0]; state_q <= S_DLA;
            end
          end else begin
            ni_q <= ni_q + 1'b1; state_q <= S_LB;
          end
        end
        S_DLA: begin
          ni_q <= NF'(a_q); state_q <= S_DLB;
        end
        S_DLB: begin
          ni_q <= NF'(b_q); state_q <= S_DGET;
        end
        S_DGET: begin
          // first visit takes the A entry, second the B entry
          if (lkb_q) begin
            sa_q <= nst_rd; ca_q <= nco_rd; lkb_q <= 1'b0; state_q <= S_DLB;
          end else begin
            sb_q <= nst_rd; cb_q <= nco_rd; aok_q <= 1'b1;
            state_q <= dirmode_q ? S_DCALC : S_RLX;
          end
        end
        S_RLX: begin
          if (relax_ok) begin ca_q <= relax_co; changed_q <= 1'b1; end
          state_q <= S_RLX2;
        end
        S_RLX2: begin
          if (relax_ok) begin cb_q <= relax_co; changed_q <= 1'b1; end
          ei_q <= ei_q + 1'b1; state_q <= S_ERD;
        end
        S_DCALC: begin
          ei_q <= ei_q + 1'b1; state_q <= S_ERD;
        end
        S_OUT: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/exit_distance_field_router.sv
// Top level: exit distance field router with output word register.
// Each word is one command against a node table and an edge table held in
// synchronous memories. Lookups scan the node or edge table one entry at a
// time. Converge clears costs node by node, then runs up to node-count
// relaxation passes; each edge in a pass costs two endpoint scans over the
// node table. A final pass assigns edge directions. The node memory has a
// single read port. One command is worked at a time; the result word waits
// in an output register, and the next command is taken once that word
// drains, at the earliest in the cycle it is taken.
module exit_distance_field_router import edfr_pkg::*; #(
  parameter int unsigned NodeSlots = NodeSlotsDef,
  parameter int unsigned EdgeSlots = EdgeSlotsDef,
  parameter int unsigned IdBits    = IdBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  logic      busy_q, ov_q, done;
  out_word_t res, od_q;
  logic      start;

  // hold a new word off while the engine runs or an earlier result word
  // stays unclaimed in this cycle
  assign in_ready_o  = !busy_q && !(ov_q && !out_ready_i);
  assign start       = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  edfr_core #(
    .NodeSlots(NodeSlots), .EdgeSlots(EdgeSlots), .IdBits(IdBits)
  ) u_core (
    .clk_i, .rst_ni, .start_i(start), .cmd_i(in_data_i),
    .done_o(done), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (start) busy_q <= 1'b1;
      else if (done) busy_q <= 1'b0;
      if (done) begin
        ov_q <= 1'b1; od_q <= res;
      end else if (out_ready_i) ov_q <= 1'b0;
    end
  end

endmodule

FILE: dv/tb_exit_distance_field_router.sv
// Testbench for the exit distance field router: directed and random command words.
module tb_exit_distance_field_router;
  import edfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS = NodeSlotsDef;
  localparam int ESLOTS = EdgeSlotsDef;
  localparam int IDLE_LIMIT = 20_000_000;
  localparam int N_RANDOM = 1600;

  typedef struct {
    in_word_t word;
    bit       drain_first;
  } pending_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;

  pending_t  pending_q[$];
  out_word_t result_q[$];
  int        words_sent = 0;
  int        mismatches = 0;
  int        idle_cycles = 0;
  bit        stim_done = 1'b0;

  // Shadow copy of the node and edge tables.
  logic [15:0] sh_node_id[NSLOTS];
  logic [1:0]  sh_node_st[NSLOTS];
  logic [7:0]  sh_node_cost[NSLOTS];
  int          sh_nodes = 0;
  logic [15:0] sh_edge_id[ESLOTS];
  logic [15:0] sh_edge_a[ESLOTS];
  logic [15:0] sh_edge_b[ESLOTS];
  logic [1:0]  sh_edge_dir[ESLOTS];
  int          sh_edges = 0;

  // Generator bookkeeping for ids that hit the tables.
  logic [15:0] node_pool[$];
  logic [15:0] edge_pool[$];

  exit_distance_field_router i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always #5 clk_i = ~clk_i;

  function automatic int find_node(logic [15:0] id);
    for (int i = 0; i < sh_nodes; i++) begin
      if (sh_node_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic int find_edge(logic [15:0] id);
    for (int i = 0; i < sh_edges; i++) begin
      if (sh_edge_id[i] == id) return i;
    end
    return -1;
  endfunction

  // Lower the cost of 'dst' through 'src'; exits and dangers hold, dangers never feed.
  function automatic bit relax_hop(int dst, int src);
    if (sh_node_st[dst] == StDanger || sh_node_st[dst] == StExit) return 1'b0;
    if (sh_node_st[src] == StDanger) return 1'b0;
    if (sh_node_cost[src] == CostInf) return 1'b0;
    if ({1'b0, sh_node_cost[src]} + 9'd1 < {1'b0, sh_node_cost[dst]}) begin
      sh_node_cost[dst] = sh_node_cost[src] + 8'd1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void converge_field();
    bit changed;
    int pass_cnt;
    int a;
    int b;
    changed = 1'b1;
    pass_cnt = 0;
    for (int i = 0; i < sh_nodes; i++) begin
      sh_node_cost[i] = (sh_node_st[i] == StExit) ? 8'd0 : CostInf;
    end
    while (changed && pass_cnt < sh_nodes) begin
      changed = 1'b0;
      pass_cnt++;
      for (int e = 0; e < sh_edges; e++) begin
        a = find_node(sh_edge_a[e]);
        b = find_node(sh_edge_b[e]);
        if (a >= 0 && b >= 0) begin
          if (relax_hop(a, b)) changed = 1'b1;
          if (relax_hop(b, a)) changed = 1'b1;
        end
      end
    end
    for (int e = 0; e < sh_edges; e++) begin
      a = find_node(sh_edge_a[e]);
      b = find_node(sh_edge_b[e]);
      sh_edge_dir[e] = DirNone;
      if (a >= 0 && b >= 0) begin
        if (sh_node_st[a] == StDanger || sh_node_st[b] == StDanger) begin
          sh_edge_dir[e] = DirBlk;
        end else if (sh_node_cost[a] > sh_node_cost[b] && sh_node_cost[b] != CostInf) begin
          sh_edge_dir[e] = DirA2B;
        end else if (sh_node_cost[b] > sh_node_cost[a] && sh_node_cost[a] != CostInf) begin
          sh_edge_dir[e] = DirB2A;
        end
      end
    end
  endfunction

  function automatic out_word_t route_result(in_word_t w);
    out_word_t r;
    logic [1:0] st;
    int k;
    r = '0;
    st = (w.status_in == 2'd3) ? StNormal : w.status_in;
    case (w.opcode)
      OpAddNode: begin
        if (sh_nodes < NSLOTS) begin
          sh_node_id[sh_nodes] = w.item_id;
          sh_node_st[sh_nodes] = st;
          sh_node_cost[sh_nodes] = (st == StExit) ? 8'd0 : CostInf;
          sh_nodes++;
          r.accepted = 1'b1;
        end
      end
      OpAddEdge: begin
        if (sh_edges < ESLOTS) begin
          sh_edge_id[sh_edges] = w.item_id;
          sh_edge_a[sh_edges] = w.end_a_id;
          sh_edge_b[sh_edges] = w.end_b_id;
          sh_edge_dir[sh_edges] = DirNone;
          sh_edges++;
          r.accepted = 1'b1;
        end
      end
      OpSetStat: begin
        k = find_node(w.item_id);
        if (k >= 0) begin
          sh_node_st[k] = st;
          r.accepted = 1'b1;
        end
      end
      OpConverge: begin
        converge_field();
        r.accepted = 1'b1;
      end
      OpRdStat: begin
        k = find_node(w.item_id);
        if (k >= 0) begin
          r.accepted = 1'b1;
          r.status_out = sh_node_st[k];
        end
      end
      OpRdCost: begin
        k = find_node(w.item_id);
        r.cost_out = CostInf;
        if (k >= 0) begin
          r.accepted = 1'b1;
          r.cost_out = sh_node_cost[k];
        end
      end
      OpRdDir: begin
        k = find_edge(w.item_id);
        if (k >= 0) begin
          r.accepted = 1'b1;
          r.direction_out = sh_edge_dir[k];
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Idle percentages by phase: sender first, receiver second.
  function automatic bit idle_now(bit is_sender);
    int pct;
    if (words_sent < 600) pct = is_sender ? 37 : 78;
    else if (words_sent < 1200) pct = is_sender ? 78 : 37;
    else pct = 0;
    return $urandom_range(0, 99) < pct;
  endfunction

  // Driver: hold each word until taken, then advance to the next one.
  always @(posedge clk_i) begin
    logic next_valid;
    next_valid = in_valid_i;
    if (in_valid_i && in_ready_o) begin
      result_q.push_back(route_result(in_data_i));
      void'(pending_q.pop_front());
      words_sent++;
      next_valid = 1'b0;
    end
    if (!next_valid && rst_ni && pending_q.size() > 0) begin
      if (!(pending_q[0].drain_first && result_q.size() > 0) && !idle_now(1'b1)) begin
        next_valid = 1'b1;
        in_data_i <= pending_q[0].word;
      end
    end
    in_valid_i <= next_valid;
  end

  // Monitor: compare each result word against the oldest prediction.
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_data_o);
      end else begin
        exp_w = result_q.pop_front();
        if (exp_w.accepted !== out_data_o.accepted ||
            exp_w.status_out !== out_data_o.status_out ||
            exp_w.cost_out !== out_data_o.cost_out ||
            exp_w.direction_out !== out_data_o.direction_out) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display({"result mismatch: exp acc=%b st=%0d cost=%0d dir=%0d",
                      " got acc=%b st=%0d cost=%0d dir=%0d"},
                     exp_w.accepted, exp_w.status_out, exp_w.cost_out, exp_w.direction_out,
                     out_data_o.accepted, out_data_o.status_out, out_data_o.cost_out,
                     out_data_o.direction_out);
          end
        end
      end
    end
    out_ready_i <= rst_ni && !idle_now(1'b0);
  end

  // Watchdog: count cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_word(logic [2:0] op, logic [15:0] id, logic [15:0] a, logic [15:0] b,
                           logic [1:0] st, bit drain = 1'b0);
    pending_t p;
    p.word = '{opcode: op, item_id: id, end_a_id: a, end_b_id: b, status_in: st};
    p.drain_first = drain;
    if (op == OpAddNode && node_pool.size() < NSLOTS) node_pool.push_back(id);
    if (op == OpAddEdge && edge_pool.size() < ESLOTS) edge_pool.push_back(id);
    pending_q.push_back(p);
  endtask

  function automatic logic [15:0] pick_node();
    if (node_pool.size() > 0 && $urandom_range(0, 99) < 85)
      return node_pool[$urandom_range(0, node_pool.size() - 1)];
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_edge();
    if (edge_pool.size() > 0 && $urandom_range(0, 99) < 85)
      return edge_pool[$urandom_range(0, edge_pool.size() - 1)];
    return 16'($urandom);
  endfunction

  initial begin
    int r;
    // Directed: empty tables, odd opcode, duplicates, status three, missing endpoint.
    push_word(OpRdCost, 16'h0000, '0, '0, StNormal);
    push_word(OpRdStat, 16'hFFFF, '0, '0, StNormal);
    push_word(OpRdDir, 16'hFFFF, '0, '0, StNormal);
    push_word(OpSetStat, 16'h0000, '0, '0, StExit);
    push_word(OpConverge, '0, '0, '0, StNormal);
    push_word(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3);
    push_word(OpAddNode, 16'h0000, '0, '0, StNormal);
    push_word(OpAddNode, 16'hFFFF, '0, '0, StExit);
    push_word(OpAddNode, 16'h1234, '0, '0, StDanger);
    push_word(OpAddNode, 16'h00AA, '0, '0, 2'd3);
    push_word(OpAddNode, 16'hFFFF, '0, '0, StNormal);
    push_word(OpAddEdge, 16'h0000, 16'h0000, 16'hFFFF, StNormal);
    push_word(OpAddEdge, 16'hFFFF, 16'h1234, 16'h0000, StNormal);
    push_word(OpAddEdge, 16'h0001, 16'h00AA, 16'h0000, StNormal);
    push_word(OpAddEdge, 16'h0002, 16'h0000, 16'h5555, StNormal);
    push_word(OpRdStat, 16'hFFFF, '0, '0, StNormal);
    push_word(OpRdStat, 16'h00AA, '0, '0, StNormal);
    push_word(OpRdCost, 16'h0000, '0, '0, StNormal);
    push_word(OpConverge, '0, '0, '0, StNormal);
    push_word(OpRdCost, 16'h00AA, '0, '0, StNormal);
    push_word(OpRdDir, 16'h0000, '0, '0, StNormal);
    push_word(OpRdDir, 16'hFFFF, '0, '0, StNormal);
    push_word(OpSetStat, 16'h00AA, '0, '0, StDanger);
    push_word(OpConverge, '0, '0, '0, StNormal);
    push_word(OpRdDir, 16'h0001, '0, '0, StNormal);
    push_word(OpRdDir, 16'h0002, '0, '0, StNormal);

    // Random: keep the graph small so converge stays short.
    for (int n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(0, 99);
      if (r < 8 && node_pool.size() < 12)
        push_word(OpAddNode, 16'($urandom), '0, '0, 2'($urandom));
      else if (r < 18 && edge_pool.size() < 20)
        push_word(OpAddEdge, 16'($urandom), pick_node(), pick_node(), 2'($urandom));
      else if (r < 26)
        push_word(OpSetStat, pick_node(), 16'($urandom), 16'($urandom), 2'($urandom));
      else if (r < 28)
        push_word(OpConverge, 16'($urandom), 16'($urandom), 16'($urandom), 2'($urandom),
                  n == 300);
      else if (r < 48)
        push_word(OpRdStat, pick_node(), '0, '0, 2'($urandom));
      else if (r < 72)
        push_word(OpRdCost, pick_node(), '0, '0, 2'($urandom));
      else if (r < 96)
        push_word(OpRdDir, pick_edge(), '0, '0, 2'($urandom));
      else
        push_word(3'd7, 16'($urandom), 16'($urandom), 16'($urandom), 2'($urandom));
    end

    // Fill both tables past capacity, then one converge over the full set.
    for (int n = node_pool.size(); n < NSLOTS + 2; n++)
      push_word(OpAddNode, 16'($urandom), '0, '0, 2'($urandom));
    for (int n = edge_pool.size(); n < ESLOTS + 2; n++)
      push_word(OpAddEdge, 16'($urandom), 16'($urandom), 16'($urandom), StNormal);
    push_word(OpConverge, '0, '0, '0, StNormal, 1'b1);
    for (int n = 0; n < 20; n++) begin
      push_word(OpRdCost, pick_node(), '0, '0, StNormal);
      push_word(OpRdDir, pick_edge(), '0, '0, StNormal);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0 && result_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
